@@ rtl/spv_pkg.sv @@
// ----------------------------------------------------------------------------
// spv_pkg
// Shared types, codes and the byte-wise reflected CRC-32 step for the
// sensor packet validator.
// ----------------------------------------------------------------------------
package spv_pkg;

    // Input stream packing
    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 1;

    // Result stream packing: status, then CRC, zero padded to whole bytes
    localparam int STATUS_W  = 3;
    localparam int CRC_W     = 32;
    localparam int M_PAD_W   = 5;
    localparam int M_TDATA_W = STATUS_W + CRC_W + M_PAD_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_EXP_TYPE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_MAGIC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_BLKSZ  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_BYTES  = 2'd3;

    // Item kinds carried on s_tuser
    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_DATA   = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TYPE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MAGIC    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BLKSZ    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOTAL    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM = 3'd5;

    // CRC-32, reflected IEEE form
    localparam logic [CRC_W-1:0] CRC_POLY_REFL = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_ALL_ONES  = 32'hFFFF_FFFF;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // One classified item as it travels through the queue
    typedef struct packed {
        logic                is_hdr;
        logic [STATUS_W-1:0] pre_status;  // type/magic/size result, ST_OK if all pass
        logic [31:0]         need;        // count * block size + header bytes
        logic [31:0]         total;
        logic [31:0]         checksum;
        logic [7:0]          data;
        logic                last;
    } qent_t;

    // Fold one byte into the running CRC, LSB first
    function automatic logic [CRC_W-1:0] crc32_fold(input logic [CRC_W-1:0] crc,
                                                    input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/spv_front.sv @@
// ----------------------------------------------------------------------------
// spv_front
// Input side: holds the configuration registers, takes input transfers,
// checks header fields and forms the expected total size.
// ----------------------------------------------------------------------------
module spv_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_wr_en,
    input  logic [spv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spv_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [spv_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic [spv_pkg::S_TUSER_W-1:0] s_tuser,
    // to queue
    output logic                          ent_valid,
    input  logic                          ent_ready,
    output spv_pkg::qent_t                ent
);
    import spv_pkg::*;

    logic [7:0]  exp_type_reg;
    logic [15:0] exp_magic_reg;
    logic [15:0] exp_blksz_reg;
    logic [7:0]  hdr_bytes_reg;

    logic        fv_reg, fv_next;
    qent_t       ent_reg, ent_next;

    logic [7:0]  f_type;
    logic [15:0] f_magic;
    logic [15:0] f_isz;
    logic [31:0] f_total;
    logic [15:0] f_cnt;
    logic [31:0] f_cksum;
    logic [7:0]  f_data;
    logic        accept;

    // Field unpacking
    assign f_type  = s_tdata[7:0];
    assign f_magic = s_tdata[23:8];
    assign f_isz   = s_tdata[39:24];
    assign f_total = s_tdata[71:40];
    assign f_cnt   = s_tdata[87:72];
    assign f_cksum = s_tdata[119:88];
    assign f_data  = s_tdata[127:120];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_type_reg  <= '0;
            exp_magic_reg <= '0;
            exp_blksz_reg <= '0;
            hdr_bytes_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_EXP_TYPE:  exp_type_reg  <= cfg_wdata[7:0];
                CFG_EXP_MAGIC: exp_magic_reg <= cfg_wdata;
                CFG_EXP_BLKSZ: exp_blksz_reg <= cfg_wdata;
                CFG_HDR_BYTES: hdr_bytes_reg <= cfg_wdata[7:0];
                default:       ;
            endcase
        end
    end

    // Take a new transfer when the stage is empty or drains this cycle
    assign s_tready = !fv_reg || ent_ready;
    assign accept   = s_tvalid && s_tready;

    // Classification; product fits 32 bits (65535*65535 + 255 < 2^32)
    always_comb begin
        ent_next = ent_reg;
        fv_next  = fv_reg;
        if (accept) begin
            fv_next             = 1'b1;
            ent_next.is_hdr     = (s_tuser[0] == CMD_HEADER);
            ent_next.need       = (32'(f_cnt) * 32'(exp_blksz_reg)) + 32'(hdr_bytes_reg);
            ent_next.total      = f_total;
            ent_next.checksum   = f_cksum;
            ent_next.data       = f_data;
            ent_next.last       = s_tlast;
            priority if (f_type != exp_type_reg) begin
                ent_next.pre_status = ST_TYPE;
            end else if (f_magic != exp_magic_reg) begin
                ent_next.pre_status = ST_MAGIC;
            end else if (f_isz != exp_blksz_reg) begin
                ent_next.pre_status = ST_BLKSZ;
            end else begin
                ent_next.pre_status = ST_OK;
            end
        end else if (ent_ready) begin
            fv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign ent_valid = fv_reg;
    assign ent       = ent_reg;

endmodule

@@ rtl/spv_queue.sv @@
// ----------------------------------------------------------------------------
// spv_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module spv_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  spv_pkg::qent_t wr_ent,
    output logic           rd_valid,
    input  logic           rd_ready,
    output spv_pkg::qent_t rd_ent
);
    import spv_pkg::*;

    qent_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, wp_next;
    logic [QPTR_W-1:0] rp_reg, rp_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push, pop;

    assign wr_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_ent   = mem[rp_reg];

    // Pointer and fill count update
    always_comb begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop  ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= wr_ent;
        end
    end

endmodule

@@ rtl/spv_back.sv @@
// ----------------------------------------------------------------------------
// spv_back
// Execution side: latches header results, runs the CRC one byte per cycle
// while the output register is free, and registers the result transfer.
// ----------------------------------------------------------------------------
module spv_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ent_valid,
    output logic                          ent_ready,
    input  spv_pkg::qent_t                ent,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [spv_pkg::M_TDATA_W-1:0] m_tdata
);
    import spv_pkg::*;

    logic [CRC_W-1:0]    crc_reg, crc_next;
    logic [STATUS_W-1:0] hstat_reg, hstat_next;
    logic [CRC_W-1:0]    cksum_reg, cksum_next;
    logic                mv_reg, mv_next;
    logic [STATUS_W-1:0] mstat_reg, mstat_next;
    logic [CRC_W-1:0]    mcrc_reg, mcrc_next;

    logic                adv;
    logic [CRC_W-1:0]    folded;
    logic [CRC_W-1:0]    fin;

    // Output register is free or being emptied
    assign adv       = !mv_reg || m_tready;
    assign ent_ready = adv;

    assign folded = crc32_fold(crc_reg, ent.data);
    assign fin    = ~folded;

    // Item execution
    always_comb begin
        crc_next   = crc_reg;
        hstat_next = hstat_reg;
        cksum_next = cksum_reg;
        mv_next    = adv ? 1'b0 : mv_reg;
        mstat_next = mstat_reg;
        mcrc_next  = mcrc_reg;
        if (ent_valid && adv) begin
            if (ent.is_hdr) begin
                if (ent.pre_status != ST_OK) begin
                    hstat_next = ent.pre_status;
                end else if (ent.total != ent.need) begin
                    hstat_next = ST_TOTAL;
                end else begin
                    hstat_next = ST_OK;
                end
                cksum_next = ent.checksum;
                crc_next   = CRC_ALL_ONES;
            end else if (ent.last) begin
                mv_next   = 1'b1;
                mcrc_next = fin;
                if (hstat_reg != ST_OK) begin
                    mstat_next = hstat_reg;
                end else if (fin != cksum_reg) begin
                    mstat_next = ST_CHECKSUM;
                end else begin
                    mstat_next = ST_OK;
                end
                crc_next = CRC_ALL_ONES;
            end else begin
                crc_next = folded;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= CRC_ALL_ONES;
            hstat_reg <= ST_OK;
            cksum_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            crc_reg   <= crc_next;
            hstat_reg <= hstat_next;
            cksum_reg <= cksum_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        mstat_reg <= mstat_next;
        mcrc_reg  <= mcrc_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, mcrc_reg, mstat_reg};

endmodule

@@ rtl/sensor_packet_validator_crc32.sv @@
// ----------------------------------------------------------------------------
// sensor_packet_validator_crc32
// Sensor packet header check plus reflected CRC-32 over the covered bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): s_tuser = 0 marks a header transfer whose fields are
//   checked against the configured type, magic, block size and total size;
//   s_tuser = 1 marks one covered byte, s_tlast on the final byte.
//   Result stream (m_*): one transfer per packet, after the last byte, with
//   the first header error, else a checksum mismatch, else ok, and the CRC.
//   Configuration: cfg_wr_en/cfg_index/cfg_wdata, written while idle.
//   Throughput: one input transfer per cycle while the receiver takes results;
//   the CRC unit folds one byte per cycle while the output register is free,
//   and the queue keeps both sides moving on their own. The last byte passes
//   the front register, then a queue entry, then the CRC step into the
//   output register.
//   Stall: a stalled receiver holds the result; the four-entry queue and the
//   front register absorb input, then s_tready drops.
//   Reset (aresetn low, synchronous): config to zero, CRC to all ones, header
//   status and latched checksum to zero, queue and result emptied.
// ----------------------------------------------------------------------------
module sensor_packet_validator_crc32 (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [spv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spv_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: pkt_type, magic, elem_size, total_size, item_count,
    //        stored_checksum, data_byte
    input  logic [spv_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    // tuser: cmd
    input  logic [spv_pkg::S_TUSER_W-1:0]  s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata: status, computed_crc, zero pad
    output logic [spv_pkg::M_TDATA_W-1:0]  m_tdata
);
    import spv_pkg::*;

    logic  f_valid, f_ready;
    qent_t f_ent;
    logic  q_valid, q_ready;
    qent_t q_ent;

    spv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .ent_valid (f_valid),
        .ent_ready (f_ready),
        .ent       (f_ent)
    );

    spv_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_ent   (f_ent),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_ent   (q_ent)
    );

    spv_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ent_valid (q_valid),
        .ent_ready (q_ready),
        .ent       (q_ent),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
